/* hdl/uwbcpt_pkg.sv */
// ----------------------------------------------------------------------------
// UWB CIR peak tracker package
// Shared word formats, operation codes, register indexes and arithmetic
// constants for the peak tracker front end, command queue and back end.
// ----------------------------------------------------------------------------
package uwbcpt_pkg;

  // Operation codes carried in the input word.
  typedef enum logic [1:0] {
    OP_SAMPLE     = 2'd0,
    OP_MARK_DEAD  = 2'd1,
    OP_READ_STATS = 2'd2,
    OP_READ_HIST  = 2'd3
  } op_t;

  // Configuration port geometry and register indexes.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_FP_WINDOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_ID_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_ID_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_ID_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_ID_3 = 3'd4;

  // Register reset values.
  localparam logic [7:0]  FP_WINDOW_RST   = 8'd20;
  localparam logic [15:0] ANCHOR_ID_0_RST = 16'h1001;
  localparam logic [15:0] ANCHOR_ID_1_RST = 16'h1002;
  localparam logic [15:0] ANCHOR_ID_2_RST = 16'h1003;
  localparam logic [15:0] ANCHOR_ID_3_RST = 16'h1004;

  // Number of anchor slots the register map provides.
  localparam int ANCHOR_SLOTS = 4;

  // Frame rate arithmetic: inst = 256e6 / dt, then (9 * rate + inst) / 10.
  localparam int             RATE_NUM_W    = 28;
  localparam logic [27:0]    RATE_NUM      = 28'd256000000;
  localparam logic [23:0]    RATE_MAX      = 24'hFFFFFF;
  localparam logic [23:0]    RATE_SEED_MIN = 24'd3;
  localparam logic [31:0]    RECIP_10      = 32'hCCCCCCCD;
  localparam int             RECIP_SHIFT   = 35;

  // Command queue geometry.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // Input word.
  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] anc_ident;
    logic [15:0] sample_value;
    logic        last_sample;
    logic [19:0] distance_mm;
    logic [39:0] timestamp_us;
    logic [7:0]  history_slot;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [1:0]  anchor_index;
    logic        error;
    logic [19:0] distance_out;
    logic [6:0]  first_path_index;
    logic [15:0] peak_level;
    logic [31:0] frames_seen;
    logic [23:0] frame_rate_q8;
    logic        alive;
    logic [19:0] history_value;
  } out_word_t;

  // Command passed from the front end to the back end.
  typedef struct packed {
    logic [1:0]  op;
    logic        err;
    logic [1:0]  slot_idx;
    logic [19:0] distance;
    logic [39:0] timestamp;
    logic [7:0]  hist_slot;
    logic [6:0]  first_path;
    logic [15:0] peak;
  } cmd_t;

  // Back end sequencer states.
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_SEED,
    BK_EMA,
    BK_COMMIT,
    BK_HADDR,
    BK_HRD,
    BK_OUT
  } bk_state_t;

endpackage

/* hdl/uwbcpt_fifo.sv */
// ----------------------------------------------------------------------------
// UWB CIR peak tracker command queue
// Small synchronous queue that decouples the sample front end from the
// per-anchor back end.
// ----------------------------------------------------------------------------
module uwbcpt_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  uwbcpt_pkg::cmd_t  push_data,
  input  logic              pop,
  output uwbcpt_pkg::cmd_t  pop_data,
  output logic              full,
  output logic              empty
);
  import uwbcpt_pkg::*;

  cmd_t              buf_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  assign full     = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = buf_r[rd_ptr_r];

  // Pointer and occupancy tracking.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* hdl/uwbcpt_front.sv */
// ----------------------------------------------------------------------------
// UWB CIR peak tracker front end
// Holds the configuration registers, absorbs impulse response samples into
// the running first-path and peak trackers, matches anchors and queues
// commands for the back end.
// ----------------------------------------------------------------------------
module uwbcpt_front #(
  parameter int MAX_SAMPLES  = 128,
  parameter int ANCHOR_COUNT = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [uwbcpt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [uwbcpt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                               in_valid,
  input  uwbcpt_pkg::in_word_t               in_word,
  output logic                               in_stall,
  input  logic                               q_full,
  output logic                               q_push,
  output uwbcpt_pkg::cmd_t                   q_data
);
  import uwbcpt_pkg::*;

  localparam int SCW  = $clog2(MAX_SAMPLES + 1);
  localparam int IW   = $clog2(MAX_SAMPLES);
  localparam int CMPW = (SCW > 8) ? SCW : 8;

  logic [7:0]     fp_window_r;
  logic [15:0]    anc_ident_r [ANCHOR_SLOTS];

  logic [SCW-1:0] cnt_r;
  logic           fpv_valid_r;
  logic [15:0]    fpv_r;
  logic [IW-1:0]  fpi_r;
  logic [15:0]    peak_r;

  logic           accept;
  logic           is_sample;
  logic           take;
  logic           in_win;
  logic           upd_fp;
  logic [IW-1:0]  fpi_new;
  logic [15:0]    peak_new;
  logic           hit;
  logic [1:0]     hit_idx;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fp_window_r    <= FP_WINDOW_RST;
      anc_ident_r[0] <= ANCHOR_ID_0_RST;
      anc_ident_r[1] <= ANCHOR_ID_1_RST;
      anc_ident_r[2] <= ANCHOR_ID_2_RST;
      anc_ident_r[3] <= ANCHOR_ID_3_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FP_WINDOW:   fp_window_r    <= cfg_wdata[7:0];
        CFG_ANCHOR_ID_0: anc_ident_r[0] <= cfg_wdata;
        CFG_ANCHOR_ID_1: anc_ident_r[1] <= cfg_wdata;
        CFG_ANCHOR_ID_2: anc_ident_r[2] <= cfg_wdata;
        CFG_ANCHOR_ID_3: anc_ident_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Anchor match; the lowest matching slot wins.
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = ANCHOR_COUNT - 1; i >= 0; i--) begin
      if (anc_ident_r[i] == in_word.anc_ident) begin
        hit     = 1'b1;
        hit_idx = 2'(i);
      end
    end
  end

  // Handshake: a word is taken whenever the queue has room.
  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  assign is_sample = (op_t'(in_word.operation) == OP_SAMPLE);

  // Running tracker update for the current sample.
  assign take     = (cnt_r < SCW'(MAX_SAMPLES));
  assign in_win   = (CMPW'(cnt_r) < CMPW'(fp_window_r));
  assign upd_fp   = take && in_win && (!fpv_valid_r || (in_word.sample_value > fpv_r));
  assign fpi_new  = upd_fp ? cnt_r[IW-1:0] : fpi_r;
  assign peak_new = (take && (in_word.sample_value > peak_r)) ? in_word.sample_value : peak_r;

  // Commands for the back end: frame commits and anchor operations.
  assign q_push = accept && (!is_sample || in_word.last_sample);

  always_comb begin
    q_data            = '0;
    q_data.op         = in_word.operation;
    q_data.err        = !hit;
    q_data.slot_idx   = hit_idx;
    q_data.distance   = in_word.distance_mm;
    q_data.timestamp  = in_word.timestamp_us;
    q_data.hist_slot  = in_word.history_slot;
    q_data.first_path = 7'(fpi_new);
    q_data.peak       = peak_new;
  end

  // Running frame state; the last sample clears it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      fpv_valid_r <= 1'b0;
      fpv_r       <= '0;
      fpi_r       <= '0;
      peak_r      <= '0;
    end else if (accept && is_sample) begin
      if (in_word.last_sample) begin
        cnt_r       <= '0;
        fpv_valid_r <= 1'b0;
        fpv_r       <= '0;
        fpi_r       <= '0;
        peak_r      <= '0;
      end else begin
        if (take) begin
          cnt_r <= cnt_r + 1'b1;
        end
        if (upd_fp) begin
          fpv_valid_r <= 1'b1;
          fpv_r       <= in_word.sample_value;
        end
        fpi_r  <= fpi_new;
        peak_r <= peak_new;
      end
    end
  end

endmodule

/* hdl/uwbcpt_back.sv */
// ----------------------------------------------------------------------------
// UWB CIR peak tracker back end
// Executes queued commands against the per-anchor state: frame commits with
// the iterative frame rate divider, mark dead, stats and history reads.
// ----------------------------------------------------------------------------
module uwbcpt_back #(
  parameter int HIST_DEPTH   = 256,
  parameter int ANCHOR_COUNT = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_empty,
  input  uwbcpt_pkg::cmd_t       q_head,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output uwbcpt_pkg::out_word_t  out_word
);
  import uwbcpt_pkg::*;

  localparam int HW        = $clog2(HIST_DEPTH);
  localparam int FW        = $clog2(HIST_DEPTH + 1);
  localparam int MEM_DEPTH = ANCHOR_COUNT * HIST_DEPTH;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int DCW       = $clog2(RATE_NUM_W);

  bk_state_t       state_r, state_nxt;
  cmd_t            cmd_r;

  // Per-anchor state.
  logic [19:0]     dist_r   [ANCHOR_SLOTS];
  logic [6:0]      fp_r     [ANCHOR_SLOTS];
  logic [15:0]     peak_r   [ANCHOR_SLOTS];
  logic [31:0]     frames_r [ANCHOR_SLOTS];
  logic [23:0]     rate_r   [ANCHOR_SLOTS];
  logic [39:0]     last_r   [ANCHOR_SLOTS];
  logic [HW-1:0]   head_r   [ANCHOR_SLOTS];
  logic [FW-1:0]   fill_r   [ANCHOR_SLOTS];
  logic [ANCHOR_SLOTS-1:0] alive_r;

  // Divider and smoothing datapath.
  logic [40:0]     rem_r;
  logic [27:0]     quo_r;
  logic [39:0]     dt_r;
  logic [DCW-1:0]  bit_r;
  logic [59:0]     prod_r;
  logic [23:0]     rate_new_r;
  logic            rate_upd_r;

  // History memory and read path.
  logic [19:0]     mem [MEM_DEPTH];
  logic [AW-1:0]   rd_addr_r;
  logic [19:0]     rd_data_r;
  logic            hv_ok_r;

  logic            out_valid_r;
  out_word_t       out_word_r;

  logic [1:0]      qa;
  logic [1:0]      a;
  logic            rate_go;
  logic            out_load;
  logic [40:0]     rem_sh;
  logic            q_bit;
  logic [23:0]     inst;
  logic [27:0]     ema_sum;
  logic            slot_ok;
  logic [HW:0]     pos_sum;
  logic [HW-1:0]   pos;
  logic            pos_ok;
  logic [AW-1:0]   wr_addr;
  logic [HW-1:0]   head_inc;
  out_word_t       res;

  assign qa = q_head.slot_idx;
  assign a  = cmd_r.slot_idx;

  // A commit updates the rate only after a previous, earlier timestamp.
  assign rate_go = (last_r[qa] != '0) && (q_head.timestamp > last_r[qa]);

  // One restoring division step per cycle.
  assign rem_sh = {rem_r[39:0], RATE_NUM[bit_r]};
  assign q_bit  = (rem_sh >= {1'b0, dt_r});

  // Saturated instantaneous rate and the smoothing sum 9 * rate + inst.
  assign inst    = (quo_r > 28'(RATE_MAX)) ? RATE_MAX : quo_r[23:0];
  assign ema_sum = {1'b0, rate_r[a], 3'b000} + 28'(rate_r[a]) + 28'(inst);

  // History position, oldest first, and whether it was ever written.
  assign slot_ok = (int'(cmd_r.hist_slot) < HIST_DEPTH);
  assign pos_sum = {1'b0, head_r[a]} + (HW+1)'(cmd_r.hist_slot);
  assign pos     = (pos_sum >= (HW+1)'(HIST_DEPTH)) ? HW'(pos_sum - (HW+1)'(HIST_DEPTH))
                                                     : pos_sum[HW-1:0];
  assign pos_ok  = slot_ok && ((fill_r[a] == FW'(HIST_DEPTH)) || (FW'(pos) < fill_r[a]));

  assign wr_addr  = AW'(int'(a) * HIST_DEPTH + int'(head_r[a]));
  assign head_inc = (int'(head_r[a]) == HIST_DEPTH - 1) ? '0 : head_r[a] + 1'b1;

  // Sequencer: next state and strobes.
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_head.err) begin
            state_nxt = BK_OUT;
          end else begin
            unique case (op_t'(q_head.op))
              OP_SAMPLE:    state_nxt = rate_go ? BK_DIV : BK_COMMIT;
              OP_READ_HIST: state_nxt = BK_HADDR;
              default:      state_nxt = BK_OUT;
            endcase
          end
        end
      end
      BK_DIV: begin
        if (bit_r == '0) begin
          state_nxt = BK_SEED;
        end
      end
      BK_SEED: begin
        state_nxt = (rate_r[a] < RATE_SEED_MIN) ? BK_COMMIT : BK_EMA;
      end
      BK_EMA:    state_nxt = BK_COMMIT;
      BK_COMMIT: state_nxt = BK_OUT;
      BK_HADDR:  state_nxt = BK_HRD;
      BK_HRD:    state_nxt = BK_OUT;
      BK_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Command capture, divider, smoothing and history address datapath.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r      <= q_head;
      rem_r      <= '0;
      quo_r      <= '0;
      bit_r      <= DCW'(RATE_NUM_W - 1);
      dt_r       <= q_head.timestamp - last_r[qa];
      rate_upd_r <= rate_go;
    end
    if (state_r == BK_DIV) begin
      rem_r <= q_bit ? (rem_sh - {1'b0, dt_r}) : rem_sh;
      quo_r <= {quo_r[26:0], q_bit};
      bit_r <= bit_r - 1'b1;
    end
    if (state_r == BK_SEED) begin
      rate_new_r <= inst;
      prod_r     <= 60'(ema_sum) * 60'(RECIP_10);
    end
    if (state_r == BK_EMA) begin
      rate_new_r <= 24'(prod_r >> RECIP_SHIFT);
    end
    if (state_r == BK_HADDR) begin
      rd_addr_r <= AW'(int'(a) * HIST_DEPTH + int'(pos));
      hv_ok_r   <= pos_ok;
    end
  end

  // History memory: written on commit, read in the cycle after the address is registered.
  always_ff @(posedge clk) begin
    if (state_r == BK_COMMIT) begin
      mem[wr_addr] <= cmd_r.distance;
    end
    if (state_r == BK_HRD) begin
      rd_data_r <= mem[rd_addr_r];
    end
  end

  // Per-anchor state updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alive_r <= '0;
      for (int i = 0; i < ANCHOR_SLOTS; i++) begin
        dist_r[i]   <= '0;
        fp_r[i]     <= '0;
        peak_r[i]   <= '0;
        frames_r[i] <= '0;
        rate_r[i]   <= '0;
        last_r[i]   <= '0;
        head_r[i]   <= '0;
        fill_r[i]   <= '0;
      end
    end else begin
      if (q_pop && !q_head.err && (op_t'(q_head.op) == OP_MARK_DEAD)) begin
        alive_r[qa] <= 1'b0;
      end
      if (state_r == BK_COMMIT) begin
        dist_r[a]   <= cmd_r.distance;
        fp_r[a]     <= cmd_r.first_path;
        peak_r[a]   <= cmd_r.peak;
        frames_r[a] <= frames_r[a] + 1'b1;
        last_r[a]   <= cmd_r.timestamp;
        alive_r[a]  <= 1'b1;
        head_r[a]   <= head_inc;
        if (fill_r[a] != FW'(HIST_DEPTH)) begin
          fill_r[a] <= fill_r[a] + 1'b1;
        end
        if (rate_upd_r) begin
          rate_r[a] <= rate_new_r;
        end
      end
    end
  end

  // Result word assembly.
  always_comb begin
    res = '0;
    if (cmd_r.err) begin
      res.error = 1'b1;
    end else begin
      res.anchor_index     = a;
      res.distance_out     = dist_r[a];
      res.first_path_index = fp_r[a];
      res.peak_level       = peak_r[a];
      res.frames_seen      = frames_r[a];
      res.frame_rate_q8    = rate_r[a];
      res.alive            = alive_r[a];
      if ((op_t'(cmd_r.op) == OP_READ_HIST) && hv_ok_r) begin
        res.history_value = rd_data_r;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

/* hdl/uwb_cir_peak_tracker_core.sv */
// ----------------------------------------------------------------------------
// UWB CIR peak tracker core
// Tracks first-path and peak of impulse response frames and keeps per-anchor
// distance, frame rate and distance history.
// ----------------------------------------------------------------------------
// Samples that do not end a frame are taken one per cycle while the queue
// has room and give no result. A last sample or an anchor operation is
// queued (four entries) for the back end, which works off one command at a
// time; a commit with a rate update first runs the one-bit-per-cycle frame
// rate divider (28 steps). Samples of the next frame keep flowing while a
// commit is worked off; the input stalls only when the queue is full.
// History is cleared logically at reset through a per-anchor fill count, so
// no clearing pass is needed.
module uwb_cir_peak_tracker_core #(
  parameter int MAX_SAMPLES  = 128,
  parameter int HIST_DEPTH   = 256,
  parameter int ANCHOR_COUNT = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [uwbcpt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [uwbcpt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                               in_valid,
  input  uwbcpt_pkg::in_word_t               in_word,
  output logic                               in_stall,
  output logic                               out_valid,
  output uwbcpt_pkg::out_word_t              out_word,
  input  logic                               out_stall
);
  import uwbcpt_pkg::*;

  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  cmd_t q_in;
  cmd_t q_out;

  // Front end: configuration, sample tracking and command issue.
  uwbcpt_front #(
    .MAX_SAMPLES  (MAX_SAMPLES),
    .ANCHOR_COUNT (ANCHOR_COUNT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_word   (in_word),
    .in_stall  (in_stall),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  // Command queue between the two halves.
  uwbcpt_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Back end: per-anchor state, rate divider and history.
  uwbcpt_back #(
    .HIST_DEPTH   (HIST_DEPTH),
    .ANCHOR_COUNT (ANCHOR_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
